>>> rtl/erpq_pkg.sv
// Shared types and constants for the echo ranger pitch quantizer.
package erpq_pkg;

    typedef enum logic [4:0] {
        PH_WAIT  = 5'b00001,
        PH_TRIG  = 5'b00010,
        PH_ARM   = 5'b00100,
        PH_COUNT = 5'b01000,
        PH_HOLD  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_HOLDOFF_TICKS = 2'd1,
        REG_MIN_WIDTH     = 2'd2,
        REG_MAX_WIDTH     = 2'd3
    } reg_index_t;

    localparam int TICK_BITS = 16;
    localparam int CFG_WIDTH_BITS = 24;
    localparam int NOTE_BITS = 8;
    localparam int NOTE_COUNT = 8;
    localparam int NOTE_INDEX_BITS = 3;

    localparam logic [TICK_BITS-1:0] TRIGGER_TICKS_RESET = 16'd20;
    localparam logic [TICK_BITS-1:0] HOLDOFF_TICKS_RESET = 16'd200;
    localparam logic [CFG_WIDTH_BITS-1:0] MIN_WIDTH_RESET = 24'd400;
    localparam logic [CFG_WIDTH_BITS-1:0] MAX_WIDTH_RESET = 24'd15000;

    // The mapped pitch runs from NOTE_BASE up to NOTE_BASE + NOTE_SPAN.
    localparam int NOTE_BASE = 61;
    localparam int NOTE_SPAN = 62;

    typedef logic [7:0] thresh_arr_t [NOTE_COUNT-1];
    typedef logic [NOTE_BITS-1:0] note_arr_t [NOTE_COUNT];

    localparam thresh_arr_t NOTE_THRESH = '{8'd68, 8'd76, 8'd84, 8'd92, 8'd99, 8'd107, 8'd115};
    localparam note_arr_t NOTE_WORDS = '{8'd61, 8'd65, 8'd71, 8'd79, 8'd88, 8'd95, 8'd110,
                                         8'd123};

endpackage

>>> rtl/echo_ranger_pitch_quantizer_unit.sv
// Echo ranger with pitch quantizer: trigger sequencing, echo width count and note mapping.
// A word accepted into the input register moves into the result registers at the tick step.
// One word per cycle, unless a stalled result word holds the flow.
// The note quantizer compares the scaled width against seven span multiples in parallel.
// Reset clears the phase, counters, note word and both valid flags, and loads the
// configuration registers with their default values.
module echo_ranger_pitch_quantizer_unit #(
    parameter int WIDTH_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  echo_level,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  trigger_level,
    output logic                  done_res,
    output logic [WIDTH_BITS-1:0] echo_width,
    output logic [7:0]            note_compare
);

    localparam int TB = erpq_pkg::TICK_BITS;
    localparam int CB = erpq_pkg::CFG_WIDTH_BITS;
    localparam int CW = (WIDTH_BITS > CB) ? WIDTH_BITS : CB;
    localparam int PW = CW + 7;

    logic [TB-1:0] trigger_ticks_reg;
    logic [TB-1:0] holdoff_ticks_reg;
    logic [CB-1:0] min_width_reg;
    logic [CB-1:0] max_width_reg;
    logic          cfg_write;

    logic in_valid_reg;
    logic echo_reg;
    logic step;
    logic item_accept;

    erpq_pkg::phase_t              phase_reg, phase_next;
    logic [TB-1:0]                 phase_ticks_reg, phase_ticks_next;
    logic [WIDTH_BITS-1:0]         width_count_reg, width_count_next;
    logic [erpq_pkg::NOTE_BITS-1:0] note_word_reg, note_word_next;

    logic                  trig_next;
    logic                  done_next;
    logic [WIDTH_BITS-1:0] width_out_next;

    logic [TB-1:0] tick_limit;
    logic [TB-1:0] tick_base;
    logic [TB-1:0] tick_inc;
    logic          tick_end;

    logic [CW-1:0] w_ext;
    logic [CW-1:0] min_ext;
    logic [CW-1:0] max_ext;
    logic [CW-1:0] clamp_w;
    logic [CW-1:0] diff;
    logic [CW-1:0] span;
    logic [PW-1:0] scaled;
    logic [PW-1:0] bound [erpq_pkg::NOTE_COUNT-1];
    logic [erpq_pkg::NOTE_INDEX_BITS-1:0] note_idx;
    logic [erpq_pkg::NOTE_BITS-1:0] note_quant;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= erpq_pkg::TRIGGER_TICKS_RESET;
            holdoff_ticks_reg <= erpq_pkg::HOLDOFF_TICKS_RESET;
            min_width_reg     <= erpq_pkg::MIN_WIDTH_RESET;
            max_width_reg     <= erpq_pkg::MAX_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (erpq_pkg::reg_index_t'(paddr[3:2]))
                erpq_pkg::REG_TRIGGER_TICKS: trigger_ticks_reg <= pwdata[TB-1:0];
                erpq_pkg::REG_HOLDOFF_TICKS: holdoff_ticks_reg <= pwdata[TB-1:0];
                erpq_pkg::REG_MIN_WIDTH:     min_width_reg     <= pwdata[CB-1:0];
                erpq_pkg::REG_MAX_WIDTH:     max_width_reg     <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (erpq_pkg::reg_index_t'(paddr[3:2]))
            erpq_pkg::REG_TRIGGER_TICKS: prdata = 32'(trigger_ticks_reg);
            erpq_pkg::REG_HOLDOFF_TICKS: prdata = 32'(holdoff_ticks_reg);
            erpq_pkg::REG_MIN_WIDTH:     prdata = 32'(min_width_reg);
            erpq_pkg::REG_MAX_WIDTH:     prdata = 32'(max_width_reg);
            default:                     prdata = '0;
        endcase
    end

    // Word handshake: the input register advances into the result register.
    assign step        = in_valid_reg && (!result_valid || !result_stall);
    assign item_stall  = in_valid_reg && !step;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            echo_reg <= echo_level;
        end
    end

    // Timed phase counter; an unknown phase restarts from zero ticks.
    always_comb
    begin
        tick_limit = (phase_reg == erpq_pkg::PH_HOLD) ? holdoff_ticks_reg : trigger_ticks_reg;
        if ((phase_reg == erpq_pkg::PH_WAIT) || (phase_reg == erpq_pkg::PH_TRIG) ||
            (phase_reg == erpq_pkg::PH_HOLD))
        begin
            tick_base = phase_ticks_reg;
        end
        else
        begin
            tick_base = '0;
        end
        tick_inc = tick_base + TB'(1);
        tick_end = (tick_limit == '0) || (tick_inc >= tick_limit) || (tick_inc == '0);
    end

    // Width clamp and note quantizer.
    always_comb
    begin
        w_ext   = CW'(width_count_reg);
        min_ext = CW'(min_width_reg);
        max_ext = CW'(max_width_reg);
        if (w_ext >= max_ext)
        begin
            clamp_w = max_ext;
        end
        else if (w_ext <= min_ext)
        begin
            clamp_w = min_ext;
        end
        else
        begin
            clamp_w = w_ext;
        end
        diff   = clamp_w - min_ext;
        span   = max_ext - min_ext;
        scaled = PW'(diff) * PW'(erpq_pkg::NOTE_SPAN);
        note_idx = '0;
        for (int k = 0; k < erpq_pkg::NOTE_COUNT - 1; k++)
        begin
            bound[k] = PW'(span) * PW'(erpq_pkg::NOTE_THRESH[k] - 8'(erpq_pkg::NOTE_BASE));
            if (scaled >= bound[k])
            begin
                note_idx = note_idx + erpq_pkg::NOTE_INDEX_BITS'(1);
            end
        end
        if (max_ext <= min_ext)
        begin
            note_quant = erpq_pkg::NOTE_WORDS[0];
        end
        else
        begin
            note_quant = erpq_pkg::NOTE_WORDS[note_idx];
        end
    end

    // One tick of the ranging sequence.
    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        width_count_next = width_count_reg;
        note_word_next   = note_word_reg;
        trig_next        = 1'b0;
        done_next        = 1'b0;
        width_out_next   = '0;
        unique case (phase_reg)
            erpq_pkg::PH_TRIG:
            begin
                trig_next        = 1'b1;
                phase_ticks_next = tick_end ? '0 : tick_inc;
                if (tick_end)
                begin
                    phase_next = erpq_pkg::PH_ARM;
                end
            end
            erpq_pkg::PH_ARM:
            begin
                if (echo_reg)
                begin
                    width_count_next = WIDTH_BITS'(1);
                    phase_next       = erpq_pkg::PH_COUNT;
                end
            end
            erpq_pkg::PH_COUNT:
            begin
                if (echo_reg)
                begin
                    if (width_count_reg != '1)
                    begin
                        width_count_next = width_count_reg + WIDTH_BITS'(1);
                    end
                end
                else
                begin
                    done_next        = 1'b1;
                    width_out_next   = width_count_reg;
                    note_word_next   = note_quant;
                    phase_next       = erpq_pkg::PH_HOLD;
                    phase_ticks_next = '0;
                end
            end
            erpq_pkg::PH_HOLD:
            begin
                phase_ticks_next = tick_end ? '0 : tick_inc;
                if (tick_end)
                begin
                    phase_next = erpq_pkg::PH_TRIG;
                end
            end
            default:
            begin
                phase_ticks_next = tick_end ? '0 : tick_inc;
                phase_next       = tick_end ? erpq_pkg::PH_TRIG : erpq_pkg::PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= erpq_pkg::PH_WAIT;
            phase_ticks_reg <= '0;
            width_count_reg <= '0;
            note_word_reg   <= '0;
            result_valid    <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg       <= phase_next;
                phase_ticks_reg <= phase_ticks_next;
                width_count_reg <= width_count_next;
                note_word_reg   <= note_word_next;
                result_valid    <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            trigger_level <= trig_next;
            done_res      <= done_next;
            echo_width    <= width_out_next;
            note_compare  <= note_word_next;
        end
    end

    // A finished measurement never coincides with a trigger pulse.
    a_done_no_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> !trigger_level)
        else $error("done word with trigger high");

    // A finished measurement always has at least one high tick.
    a_done_width: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> echo_width != '0)
        else $error("done word with zero width");

    // The note word is zero only before the first measurement, else a table entry.
    a_note_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (note_compare == 8'd0) || (note_compare == 8'd61) ||
            (note_compare == 8'd65) || (note_compare == 8'd71) ||
            (note_compare == 8'd79) || (note_compare == 8'd88) ||
            (note_compare == 8'd95) || (note_compare == 8'd110) ||
            (note_compare == 8'd123))
        else $error("note word outside table");

    // A stalled result word must not be overwritten by a new tick.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> !step)
        else $error("result word overwritten while stalled");

endmodule
